// ----- rtl/balance_pid_stepper_driver_top_defines.svh -----
// Assertion macros for the balance controller.
// Used by the top level only; no other dependencies.
`ifndef BALANCE_PID_STEPPER_DRIVER_TOP_DEFINES_SVH
`define BALANCE_PID_STEPPER_DRIVER_TOP_DEFINES_SVH

// same-cycle implication
`define BPSD_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("bpsd assertion failed");

// next-cycle implication
`define BPSD_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("bpsd assertion failed");

`endif

// ----- rtl/bpsd_pkg.sv -----
// Package: request types, config struct, sequencer steps, constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
package bpsd_pkg;

	localparam int unsigned FRAC_BITS = 16;

	localparam logic signed [33:0] GYRO_SCALE  = 34'sd326418;
	localparam logic signed [33:0] ACCEL_SCALE = 34'sd46540266;
	localparam logic signed [33:0] DT_SCALE    = 34'sd42949673;
	localparam logic signed [39:0] DERIV_MULT  = 40'sd100;
	localparam logic [63:0] STEP_LIMIT = 64'd75000000 << FRAC_BITS;
	localparam logic [40:0] TERM_CAP = 41'd1 << 40;
	localparam logic [50:0] HI_LIMIT = 51'd1 << 39;

	typedef struct packed {
		logic              cmd;
		logic signed [15:0] gyro_raw;
		logic signed [15:0] accel_raw;
	} item_req_t;

	typedef struct packed {
		logic signed [31:0] tilt_angle;
		logic signed [31:0] drive_speed;
		logic               step_pulse;
		logic               step_direction;
	} result_req_t;

	typedef enum logic [2:0] {
		REG_SETPOINT, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
		REG_WEIGHT, REG_GYRO_BIAS, REG_TICK_INC, REG_MIN_SPEED
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] setpoint_angle;
		logic [26:0]        gain_p;
		logic [26:0]        gain_i;
		logic [26:0]        gain_d;
		logic [15:0]        filter_weight;
		logic signed [15:0] gyro_bias;
		logic [19:0]        tick_increment;
		logic [26:0]        min_speed;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_G, ST_A, ST_W1, ST_W2, ST_E, ST_INT,
		ST_PH, ST_PL, ST_IH, ST_IL, ST_DH, ST_DL, ST_SPD,
		ST_T1, ST_TK, ST_DONE
	} step_t;

	typedef struct packed {
		step_t op;
		logic  capture;
		logic  load_out;
	} dp_cmd_t;

	function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] v,
		input int unsigned s);
		logic signed [67:0] half;
		half = 68'sd1 <<< (s - 1);
		if (v < 0)
			return (v + half - 68'sd1) >>> s;
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -68'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [67:0] v);
		if (v > 68'sd140737488355327)
			return 48'sh7FFFFFFFFFFF;
		if (v < -68'sd140737488355328)
			return 48'sh800000000000;
		return v[47:0];
	endfunction

endpackage

// ----- rtl/bpsd_cfg.sv -----
// Configuration register file.
// Depends on bpsd_pkg.
`timescale 1ns / 1ps
module bpsd_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [26:0]          cfg_data,
	output bpsd_pkg::cfg_t       cfg
);
	import bpsd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_angle <= -24'sd262144;
			cfg_q.gain_p         <= 27'd393216;
			cfg_q.gain_i         <= 27'd13107200;
			cfg_q.gain_d         <= 27'd655;
			cfg_q.filter_weight  <= 16'd65470;
			cfg_q.gyro_bias      <= 16'sd65;
			cfg_q.tick_increment <= 20'd50000;
			cfg_q.min_speed      <= 27'd32768;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SETPOINT:  cfg_q.setpoint_angle <= cfg_data[23:0];
				REG_GAIN_P:    cfg_q.gain_p <= cfg_data;
				REG_GAIN_I:    cfg_q.gain_i <= cfg_data;
				REG_GAIN_D:    cfg_q.gain_d <= cfg_data;
				REG_WEIGHT:    cfg_q.filter_weight <= cfg_data[15:0];
				REG_GYRO_BIAS: cfg_q.gyro_bias <= cfg_data[15:0];
				REG_TICK_INC:  cfg_q.tick_increment <= cfg_data[19:0];
				REG_MIN_SPEED: cfg_q.min_speed <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/bpsd_ctrl.sv -----
// Sequencer: steps one request through the datapath, owns the handshakes.
// Depends on bpsd_pkg.
`timescale 1ns / 1ps
module bpsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              item_cmd,
	output logic              result_valid,
	input  logic              result_stall,
	output bpsd_pkg::dp_cmd_t dp_cmd
);
	import bpsd_pkg::*;

	step_t state_q, state_d;
	logic  out_valid_q;

	assign item_stall = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		dp_cmd.op = state_q;
		dp_cmd.capture = 1'b0;
		dp_cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					dp_cmd.capture = 1'b1;
					state_d = item_cmd ? ST_T1 : ST_G;
				end
			end
			ST_G:   state_d = ST_A;
			ST_A:   state_d = ST_W1;
			ST_W1:  state_d = ST_W2;
			ST_W2:  state_d = ST_E;
			ST_E:   state_d = ST_INT;
			ST_INT: state_d = ST_PH;
			ST_PH:  state_d = ST_PL;
			ST_PL:  state_d = ST_IH;
			ST_IH:  state_d = ST_IL;
			ST_IL:  state_d = ST_DH;
			ST_DH:  state_d = ST_DL;
			ST_DL:  state_d = ST_SPD;
			ST_SPD: state_d = ST_DONE;
			ST_T1:  state_d = ST_TK;
			ST_TK:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					dp_cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/bpsd_dp.sv -----
// Datapath: filter, PID and step timing around one shared 34x34 multiplier.
// Depends on bpsd_pkg.
`timescale 1ns / 1ps
module bpsd_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpsd_pkg::dp_cmd_t     dp_cmd,
	input  bpsd_pkg::cfg_t        cfg,
	input  bpsd_pkg::item_req_t   item,
	output bpsd_pkg::result_req_t result
);
	import bpsd_pkg::*;

	logic signed [31:0] angle_q, prev_q, speed_q, e_q;
	logic signed [47:0] integ_q;
	logic [31:0]        tacc_q, tnew_q, mag_q;
	logic               dir_q, pulse_q;

	logic signed [15:0] gyro_q, accel_q;
	logic signed [20:0] g_q;
	logic signed [26:0] a_q;
	logic signed [51:0] wsum_q;
	logic signed [39:0] d_q;
	logic [50:0]        hi_q;
	logic               neg_q;
	logic signed [43:0] sum_q;
	result_req_t        result_q;

	logic signed [33:0] op_a, op_b;
	logic signed [67:0] prod;
	logic signed [47:0] tval;
	logic [47:0]        tmag;
	logic [26:0]        tgain;
	logic [63:0]        p_full, r_full;
	logic [40:0]        r_cap;
	logic signed [41:0] term;
	logic [32:0]        tsum;

	assign result = result_q;
	assign prod = op_a * op_b;

	always_comb begin
		case (dp_cmd.op)
			ST_PH, ST_PL: begin
				tval = 48'(e_q);
				tgain = cfg.gain_p;
			end
			ST_IH, ST_IL: begin
				tval = integ_q;
				tgain = cfg.gain_i;
			end
			default: begin
				tval = 48'(d_q);
				tgain = cfg.gain_d;
			end
		endcase
		tmag = tval[47] ? 48'(-tval) : 48'(tval);
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (dp_cmd.op)
			ST_G: begin
				op_a = 34'(gyro_q) - 34'(cfg.gyro_bias);
				op_b = GYRO_SCALE;
			end
			ST_A: begin
				op_a = 34'(accel_q);
				op_b = ACCEL_SCALE;
			end
			ST_W1: begin
				op_a = 34'(angle_q) + 34'(g_q);
				op_b = $signed({18'd0, cfg.filter_weight});
			end
			ST_W2: begin
				op_a = 34'(a_q);
				op_b = 34'sd65536 - $signed({18'd0, cfg.filter_weight});
			end
			ST_INT: begin
				op_a = 34'(e_q);
				op_b = DT_SCALE;
			end
			ST_PH, ST_IH, ST_DH: begin
				op_a = $signed({10'd0, tmag[47:24]});
				op_b = $signed({7'd0, tgain});
			end
			ST_PL, ST_IL, ST_DL: begin
				op_a = $signed({10'd0, tmag[23:0]});
				op_b = $signed({7'd0, tgain});
			end
			ST_TK: begin
				op_a = $signed({2'd0, tnew_q});
				op_b = $signed({2'd0, mag_q});
			end
			default: ;
		endcase
	end

	always_comb begin
		p_full = (64'(hi_q) << 24) + 64'(prod[50:0]);
		r_full = (p_full + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (hi_q >= HI_LIMIT || r_full > 64'(TERM_CAP))
			r_cap = TERM_CAP;
		else
			r_cap = r_full[40:0];
		term = neg_q ? -$signed({1'b0, r_cap}) : $signed({1'b0, r_cap});
		tsum = 33'(tacc_q) + 33'(cfg.tick_increment);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			integ_q <= '0;
			prev_q <= '0;
			speed_q <= '0;
			tacc_q <= '0;
			dir_q <= 1'b0;
		end else begin
			case (dp_cmd.op)
				ST_W2: angle_q <= sat32(rnd_shr(68'(wsum_q) + prod, 16));
				ST_INT: begin
					integ_q <= sat48(68'(integ_q) + rnd_shr(prod, 32));
					prev_q <= e_q;
				end
				ST_SPD: speed_q <= sat32(68'(sum_q));
				ST_TK: begin
					if (mag_q > 32'(cfg.min_speed) && prod[63:0] >= STEP_LIMIT) begin
						dir_q <= !speed_q[31] && (speed_q != '0);
						tacc_q <= '0;
					end else begin
						tacc_q <= tnew_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			gyro_q <= item.gyro_raw;
			accel_q <= item.accel_raw;
			pulse_q <= 1'b0;
		end
		case (dp_cmd.op)
			ST_G:  g_q <= 21'(rnd_shr(prod, 32 - FRAC_BITS));
			ST_A:  a_q <= 27'(rnd_shr(prod, 32 - FRAC_BITS));
			ST_W1: wsum_q <= prod[51:0];
			ST_E: begin
				e_q <= sat32(68'(24'(cfg.setpoint_angle)) - 68'(angle_q)
					+ 68'(34'(cfg.setpoint_angle)) - 68'(34'(cfg.setpoint_angle)));
				sum_q <= '0;
			end
			ST_INT: d_q <= (40'(e_q) - 40'(prev_q)) * DERIV_MULT;
			ST_PH, ST_IH, ST_DH: begin
				hi_q <= prod[50:0];
				neg_q <= tval[47];
			end
			ST_PL, ST_IL, ST_DL: sum_q <= sum_q + 44'(term);
			ST_T1: begin
				tnew_q <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
				mag_q <= speed_q[31] ? 32'(-speed_q) : 32'(speed_q);
			end
			ST_TK: pulse_q <= mag_q > 32'(cfg.min_speed) && prod[63:0] >= STEP_LIMIT;
			default: ;
		endcase
		if (dp_cmd.load_out) begin
			result_q.tilt_angle <= angle_q;
			result_q.drive_speed <= speed_q;
			result_q.step_pulse <= pulse_q;
			result_q.step_direction <= dir_q;
		end
	end

endmodule

// ----- rtl/balance_pid_stepper_driver_top.sv -----
// Channel   | handshake              | payload
// item      | item_valid/item_stall  | bpsd_pkg::item_req_t
// result    | result_valid/result_stall | bpsd_pkg::result_req_t
// cfg       | cfg_valid/cfg_ready    | cfg_index, cfg_data
// Sensor request: steps G, A, W1, W2, E, INT, PH, PL, IH, IL, DH, DL, SPD and DONE
// (shared multiplier, one product a cycle). Tick request: T1, TK and DONE.
// One request in flight; next accepted once the result is loaded, even if still stalled.
// Reset is asynchronous, active low, and restores defaults.
// Depends on bpsd_pkg, bpsd_cfg, bpsd_ctrl, bpsd_dp and the defines header.
`timescale 1ns / 1ps
`include "balance_pid_stepper_driver_top_defines.svh"
module balance_pid_stepper_driver_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  bpsd_pkg::item_req_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output bpsd_pkg::result_req_t result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [26:0]           cfg_data
);
	import bpsd_pkg::*;

	cfg_t    cfg;
	dp_cmd_t dp_cmd;
	logic    step_out;

	assign step_out = result_valid && result.step_pulse;

	bpsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpsd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_cmd     (item.cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dp_cmd       (dp_cmd)
	);

	bpsd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.dp_cmd (dp_cmd),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

	`BPSD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)
	`BPSD_ASSERT_NOW(a_pulse_speed, clk, arst_n, step_out, result.drive_speed != 32'sd0)
	`BPSD_ASSERT_NOW(a_pulse_dir, clk, arst_n, step_out, result.step_direction == !result.drive_speed[31])

endmodule
